### hw/rtl/tccw_pkg.sv
// shared types, constants and helpers for the text console cell writer
// no dependencies; used by every module of the block
package tccw_pkg;

  // screen geometry
  localparam int SCREEN_ROWS = 25;
  localparam int SCREEN_COLS = 80;
  localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
  localparam int MOVE_COUNT  = (SCREEN_ROWS - 1) * SCREEN_COLS;

  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int COL_W  = $clog2(SCREEN_COLS);
  localparam int CELL_W = $clog2(CELL_COUNT);

  // character and style constants
  localparam logic [7:0] BLANK_CHAR   = 8'd32;
  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0] RESET_STYLE  = 8'd15;

  // operation codes on the input channel
  localparam logic [1:0] OP_WRITE      = 2'd0;
  localparam logic [1:0] OP_SET_CURSOR = 2'd1;
  localparam logic [1:0] OP_CLEAR      = 2'd2;
  localparam logic [1:0] OP_READ       = 2'd3;

  // classified command kinds
  localparam logic [2:0] CMD_CHAR       = 3'd0;
  localparam logic [2:0] CMD_NEWLINE    = 3'd1;
  localparam logic [2:0] CMD_SET_CURSOR = 3'd2;
  localparam logic [2:0] CMD_CLEAR      = 3'd3;
  localparam logic [2:0] CMD_READ       = 3'd4;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [7:0] char_style;
    logic [4:0] pos_row;
    logic [6:0] pos_col;
  } tccw_in_t;

  typedef struct packed {
    logic [10:0] cursor_offset;
    logic [7:0]  cell_char;
    logic [7:0]  cell_style;
    logic        scrolled;
  } tccw_out_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        char_code;
    logic [7:0]        char_style;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] idx;
  } tccw_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tccw_q_status_t;

  // linear cell index of a row and column
  function automatic logic [CELL_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    return CELL_W'(row) * CELL_W'(SCREEN_COLS) + CELL_W'(col);
  endfunction

endpackage

### hw/rtl/tccw_front.sv
// front stage: accepts input items, saturates positions and classifies them
// depends on tccw_pkg; feeds the command queue
module tccw_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  tccw_pkg::tccw_in_t      in_data_i,
  input  tccw_pkg::tccw_q_status_t q_stat_i,
  output logic                    push_o,
  output tccw_pkg::tccw_cmd_t     cmd_o
);

  logic                vld_r, vld_nxt;
  tccw_pkg::tccw_cmd_t cmd_r, cmd_nxt;
  logic                accept;

  // handshake: hold while the front register is loaded and the queue is full
  assign in_stall_o = vld_r && q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = vld_r && !q_stat_i.full;
  assign cmd_o      = cmd_r;

  // classify and saturate
  always_comb begin
    cmd_nxt            = cmd_r;
    cmd_nxt.char_code  = in_data_i.char_code;
    cmd_nxt.char_style = in_data_i.char_style;
    if (32'(in_data_i.pos_row) > 32'(tccw_pkg::SCREEN_ROWS - 1)) begin
      cmd_nxt.row = tccw_pkg::ROW_W'(tccw_pkg::SCREEN_ROWS - 1);
    end else begin
      cmd_nxt.row = tccw_pkg::ROW_W'(in_data_i.pos_row);
    end
    if (32'(in_data_i.pos_col) > 32'(tccw_pkg::SCREEN_COLS - 1)) begin
      cmd_nxt.col = tccw_pkg::COL_W'(tccw_pkg::SCREEN_COLS - 1);
    end else begin
      cmd_nxt.col = tccw_pkg::COL_W'(in_data_i.pos_col);
    end
    cmd_nxt.idx = tccw_pkg::cell_index(cmd_nxt.row, cmd_nxt.col);
    case (in_data_i.operation)
      tccw_pkg::OP_WRITE: begin
        if (in_data_i.char_code == tccw_pkg::NEWLINE_CHAR) begin
          cmd_nxt.kind = tccw_pkg::CMD_NEWLINE;
        end else begin
          cmd_nxt.kind = tccw_pkg::CMD_CHAR;
        end
      end
      tccw_pkg::OP_SET_CURSOR: cmd_nxt.kind = tccw_pkg::CMD_SET_CURSOR;
      tccw_pkg::OP_CLEAR:      cmd_nxt.kind = tccw_pkg::CMD_CLEAR;
      default:                 cmd_nxt.kind = tccw_pkg::CMD_READ;
    endcase
  end

  // stage valid
  always_comb begin
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (push_o) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

### hw/rtl/tccw_queue.sv
// small command queue between the front stage and the back end
// depends on tccw_pkg
module tccw_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push_i,
  input  tccw_pkg::tccw_cmd_t      push_data_i,
  input  logic                     pop_i,
  output tccw_pkg::tccw_cmd_t      head_o,
  output tccw_pkg::tccw_q_status_t stat_o
);

  tccw_pkg::tccw_cmd_t         entry_r [tccw_pkg::QUEUE_DEPTH];
  logic [tccw_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tccw_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tccw_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign head_o       = entry_r[rd_ptr_r];
  assign stat_o.full  = (count_r == tccw_pkg::QCNT_W'(tccw_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (count_r == '0);

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      if (wr_ptr_r == tccw_pkg::QPTR_W'(tccw_pkg::QUEUE_DEPTH - 1)) begin
        wr_ptr_nxt = '0;
      end else begin
        wr_ptr_nxt = wr_ptr_r + 1'b1;
      end
    end
    if (pop_i) begin
      if (rd_ptr_r == tccw_pkg::QPTR_W'(tccw_pkg::QUEUE_DEPTH - 1)) begin
        rd_ptr_nxt = '0;
      end else begin
        rd_ptr_nxt = rd_ptr_r + 1'b1;
      end
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      entry_r[wr_ptr_r] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (count_r != tccw_pkg::QCNT_W'(tccw_pkg::QUEUE_DEPTH)))
    else $error("push into full command queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> (count_r != '0))
    else $error("pop from empty command queue");
`endif

endmodule

### hw/rtl/tccw_back.sv
// back end: executes commands on the cell store and cursor, owns the result register
// depends on tccw_pkg; holds the cell memory and the scroll/clear sequencer
module tccw_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tccw_pkg::tccw_cmd_t      cmd_i,
  input  tccw_pkg::tccw_q_status_t q_stat_i,
  output logic                     pop_o,
  input  logic                     cfg_we_i,
  input  logic [7:0]               cfg_style_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output tccw_pkg::tccw_out_t      out_data_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_SCROLL = 2'd2;
  localparam logic [1:0] ST_FILL   = 2'd3;

  localparam logic [tccw_pkg::ROW_W-1:0]  LAST_ROW = tccw_pkg::ROW_W'(tccw_pkg::SCREEN_ROWS - 1);
  localparam logic [tccw_pkg::COL_W-1:0]  LAST_COL = tccw_pkg::COL_W'(tccw_pkg::SCREEN_COLS - 1);
  localparam logic [tccw_pkg::CELL_W-1:0] LAST_CELL =
    tccw_pkg::CELL_W'(tccw_pkg::CELL_COUNT - 1);
  localparam logic [tccw_pkg::CELL_W-1:0] MOVE_END = tccw_pkg::CELL_W'(tccw_pkg::MOVE_COUNT);

  logic [1:0]                  state_r, state_nxt;
  logic [tccw_pkg::CELL_W-1:0] cnt_r, cnt_nxt;
  logic [tccw_pkg::ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [tccw_pkg::COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [7:0]                  style_r, style_nxt;
  logic [7:0]                  fill_style_r, fill_style_nxt;
  logic                        emit_r, emit_nxt;
  logic                        scroll_flag_r, scroll_flag_nxt;
  logic                        out_vld_r, out_vld_nxt;
  tccw_pkg::tccw_out_t         out_data_r;
  tccw_pkg::tccw_out_t         res_data;
  logic                        res_load;
  logic                        out_free;

  // cell store ports
  logic [15:0]                 mem [tccw_pkg::CELL_COUNT];
  logic                        mem_we;
  logic [tccw_pkg::CELL_W-1:0] mem_waddr;
  logic [15:0]                 mem_wdata;
  logic [tccw_pkg::CELL_W-1:0] mem_raddr;
  logic [15:0]                 rd_data_r;

  assign out_free    = !out_vld_r || !out_stall_i;
  assign out_valid_o = out_vld_r;
  assign out_data_o  = out_data_r;

  // configuration register
  always_comb begin
    style_nxt = cfg_we_i ? cfg_style_i : style_r;
  end

  // command sequencer
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    cur_row_nxt     = cur_row_r;
    cur_col_nxt     = cur_col_r;
    fill_style_nxt  = fill_style_r;
    emit_nxt        = emit_r;
    scroll_flag_nxt = scroll_flag_r;
    pop_o           = 1'b0;
    res_load        = 1'b0;
    res_data        = '0;
    mem_we          = 1'b0;
    mem_waddr       = cnt_r;
    mem_wdata       = {fill_style_r, tccw_pkg::BLANK_CHAR};
    mem_raddr       = cnt_r + tccw_pkg::CELL_W'(tccw_pkg::SCREEN_COLS);

    case (state_r)
      ST_IDLE: begin
        if (!q_stat_i.empty && out_free) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            tccw_pkg::CMD_CHAR, tccw_pkg::CMD_NEWLINE: begin
              // store a plain character, then advance or wrap the cursor
              if (cmd_i.kind == tccw_pkg::CMD_CHAR) begin
                mem_we    = 1'b1;
                mem_waddr = tccw_pkg::cell_index(cur_row_r, cur_col_r);
                mem_wdata = {cmd_i.char_style, cmd_i.char_code};
              end
              if (cmd_i.kind == tccw_pkg::CMD_NEWLINE || cur_col_r == LAST_COL) begin
                cur_col_nxt = '0;
                if (cur_row_r == LAST_ROW) begin
                  state_nxt = ST_SCROLL;
                  cnt_nxt   = '0;
                end else begin
                  cur_row_nxt = cur_row_r + 1'b1;
                  res_load    = 1'b1;
                end
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
                res_load    = 1'b1;
              end
            end
            tccw_pkg::CMD_SET_CURSOR: begin
              cur_row_nxt = cmd_i.row;
              cur_col_nxt = cmd_i.col;
              res_load    = 1'b1;
            end
            tccw_pkg::CMD_CLEAR: begin
              cur_row_nxt     = '0;
              cur_col_nxt     = '0;
              fill_style_nxt  = style_r;
              emit_nxt        = 1'b1;
              scroll_flag_nxt = 1'b0;
              cnt_nxt         = '0;
              state_nxt       = ST_FILL;
            end
            tccw_pkg::CMD_READ: begin
              mem_raddr = cmd_i.idx;
              state_nxt = ST_READ;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      // read data is back from the store
      ST_READ: begin
        res_load  = 1'b1;
        state_nxt = ST_IDLE;
      end

      // move every row up: read one row ahead, write the cell before
      ST_SCROLL: begin
        if (cnt_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r - 1'b1;
          mem_wdata = rd_data_r;
        end
        if (cnt_r == MOVE_END) begin
          state_nxt       = ST_FILL;
          fill_style_nxt  = style_r;
          emit_nxt        = 1'b1;
          scroll_flag_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // blank fill up to the last cell
      default: begin
        mem_we = 1'b1;
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
          res_load  = emit_r;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    endcase

    // result fields
    res_data.cursor_offset = 11'(tccw_pkg::cell_index(cur_row_nxt, cur_col_nxt));
    if (state_r == ST_READ) begin
      res_data.cell_char  = rd_data_r[7:0];
      res_data.cell_style = rd_data_r[15:8];
    end
    res_data.scrolled = (state_r == ST_FILL) && scroll_flag_r;
  end

  // result register valid
  always_comb begin
    if (res_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && out_stall_i) begin
      out_vld_nxt = 1'b1;
    end else begin
      out_vld_nxt = 1'b0;
    end
  end

  // control state; reset starts a blank fill of the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_FILL;
      cnt_r         <= '0;
      cur_row_r     <= '0;
      cur_col_r     <= '0;
      style_r       <= tccw_pkg::RESET_STYLE;
      fill_style_r  <= tccw_pkg::RESET_STYLE;
      emit_r        <= 1'b0;
      scroll_flag_r <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      cur_row_r     <= cur_row_nxt;
      cur_col_r     <= cur_col_nxt;
      style_r       <= style_nxt;
      fill_style_r  <= fill_style_nxt;
      emit_r        <= emit_nxt;
      scroll_flag_r <= scroll_flag_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res_data;
    end
  end

  // cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_row_r <= LAST_ROW) && (cur_col_r <= LAST_COL))
    else $error("cursor outside the screen");

  a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && out_vld_r) |-> !out_stall_i)
    else $error("result register overwritten while stalled");

  a_scroll_to_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL && cnt_r == MOVE_END) |=>
      (state_r == ST_FILL && cnt_r == MOVE_END && scroll_flag_r))
    else $error("scroll did not hand over to bottom row fill");
`endif

endmodule

### hw/rtl/text_console_cell_writer_unit.sv
// Text console cell writer, 25 rows by 80 columns.
// Input channel in_valid/in_stall/in_data carries one operation per transfer:
// write character at the cursor, set cursor, clear screen or read cell.
// Output channel out_valid/out_stall/out_data returns exactly one result per
// item, in order: cursor offset after the item, read cell bytes, scroll flag.
// cfg_valid/cfg_ready/cfg_data writes the default style; cfg_ready is always
// high, and writes belong only to quiet periods with no item in flight.
// Path: a transfer in passes a front register and a two-entry queue, then the
// back end executes it and loads the result register; a cell read also waits
// for the registered store read, in ST_READ.
// Throughput: one character write or cursor set per cycle unless a stalled
// result, read, scroll or clear holds the back end. A scroll walks the store
// through its single read and write port, one cell per cycle; so does a clear.
// Reset: synchronous, active low. After reset the store is filled with blank
// cells in style 15, one cell per cycle; items are taken into the front register
// and queue meanwhile and run once the fill is done.
// When out_stall is high a pending result holds; the back end takes no new item,
// the queue fills and in_stall rises once the queue and front register are full.
// Depends on tccw_pkg, tccw_front, tccw_queue and tccw_back.
module text_console_cell_writer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tccw_pkg::tccw_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tccw_pkg::tccw_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  tccw_pkg::tccw_cmd_t      front_cmd;
  tccw_pkg::tccw_cmd_t      head_cmd;
  tccw_pkg::tccw_q_status_t q_stat;
  logic                     push;
  logic                     pop;
  logic                     cfg_we;

  // configuration is always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  tccw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  tccw_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (front_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .stat_o      (q_stat)
  );

  tccw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (head_cmd),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .cfg_we_i    (cfg_we),
    .cfg_style_i (cfg_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

endmodule

### sim/text_console_cell_writer_unit_tb.sv
// self-checking testbench for text_console_cell_writer_unit: directed and random console
// operations through a queue-fed driver, checked against a screen and cursor predictor
// depends on tccw_pkg and text_console_cell_writer_unit from the rtl
module text_console_cell_writer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // quiet cycles allowed: reset fill plus a scroll or clear, a long hold and bursts
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned LONG_HOLD      = 600;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tccw_pkg::tccw_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tccw_pkg::tccw_out_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_data = 8'd0;

  // stimulus and checking state
  tccw_pkg::tccw_in_t  queued_ops[$];
  tccw_pkg::tccw_out_t awaited_reports[$];
  int unsigned         fault_count = 0;
  logic                quiet_run = 1'b0;
  logic                hold_request = 1'b0;

  // predictor state: screen contents, cursor and blank style
  logic [15:0] screen_cells [0:tccw_pkg::CELL_COUNT-1];
  int unsigned cursor_pos;
  logic [7:0]  blank_style;

  text_console_cell_writer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // fill the whole screen with spaces in the current blank style
  function automatic void blank_screen();
    for (int i = 0; i < tccw_pkg::CELL_COUNT; i++) begin
      screen_cells[i] = {blank_style, tccw_pkg::BLANK_CHAR};
    end
  endfunction

  // predicted result of one operation, updating screen and cursor
  function automatic tccw_pkg::tccw_out_t apply_console_op(input tccw_pkg::tccw_in_t op);
    tccw_pkg::tccw_out_t rpt;
    int unsigned row;
    int unsigned col;
    int unsigned pos;
    rpt = '0;
    row = (op.pos_row > tccw_pkg::SCREEN_ROWS - 1) ? tccw_pkg::SCREEN_ROWS - 1 : op.pos_row;
    col = (op.pos_col > tccw_pkg::SCREEN_COLS - 1) ? tccw_pkg::SCREEN_COLS - 1 : op.pos_col;
    pos = row * tccw_pkg::SCREEN_COLS + col;
    if (cursor_pos >= tccw_pkg::CELL_COUNT) cursor_pos = 0;
    case (op.operation)
      tccw_pkg::OP_WRITE: begin
        if (op.char_code == tccw_pkg::NEWLINE_CHAR) begin
          cursor_pos = (cursor_pos / tccw_pkg::SCREEN_COLS + 1) * tccw_pkg::SCREEN_COLS;
        end else begin
          screen_cells[cursor_pos] = {op.char_style, op.char_code};
          cursor_pos++;
        end
        // past the last cell: move every row up and blank the bottom row
        if (cursor_pos >= tccw_pkg::CELL_COUNT) begin
          for (int i = 0; i < tccw_pkg::CELL_COUNT; i++) begin
            if (i < tccw_pkg::MOVE_COUNT) begin
              screen_cells[i] = screen_cells[i + tccw_pkg::SCREEN_COLS];
            end else begin
              screen_cells[i] = {blank_style, tccw_pkg::BLANK_CHAR};
            end
          end
          cursor_pos = tccw_pkg::MOVE_COUNT;
          rpt.scrolled = 1'b1;
        end
      end
      tccw_pkg::OP_SET_CURSOR: begin
        cursor_pos = pos;
      end
      tccw_pkg::OP_CLEAR: begin
        blank_screen();
        cursor_pos = 0;
      end
      default: begin
        rpt.cell_char  = screen_cells[pos][7:0];
        rpt.cell_style = screen_cells[pos][15:8];
      end
    endcase
    rpt.cursor_offset = 11'(cursor_pos);
    return rpt;
  endfunction

  function automatic tccw_pkg::tccw_in_t pack_op(input logic [1:0] kind, input logic [7:0] ch,
                                                 input logic [7:0] st, input logic [4:0] row,
                                                 input logic [6:0] col);
    tccw_pkg::tccw_in_t op;
    op.operation  = kind;
    op.char_code  = ch;
    op.char_style = st;
    op.pos_row    = row;
    op.pos_col    = col;
    return op;
  endfunction

  // random part: mostly line bursts near the bottom, the rest raw noise
  task automatic queue_phase(input int unsigned count);
    int unsigned        goal;
    int unsigned        n;
    tccw_pkg::tccw_in_t op;
    goal = queued_ops.size() + count;
    while (queued_ops.size() < goal) begin
      if ($urandom_range(0, 9) < 7) begin
        queued_ops.push_back(pack_op(tccw_pkg::OP_SET_CURSOR, 8'($urandom), 8'($urandom),
          $urandom_range(0, 1) ? 5'd24 : 5'($urandom_range(0, 31)),
          $urandom_range(0, 1) ? 7'($urandom_range(60, 79)) : 7'($urandom_range(0, 127))));
        n = $urandom_range(1, 12);
        repeat (n) begin
          queued_ops.push_back(pack_op(tccw_pkg::OP_WRITE,
            ($urandom_range(0, 7) == 0) ? tccw_pkg::NEWLINE_CHAR : 8'($urandom), 8'($urandom),
            5'($urandom), 7'($urandom)));
        end
        n = $urandom_range(1, 3);
        repeat (n) begin
          queued_ops.push_back(pack_op(tccw_pkg::OP_READ, 8'($urandom), 8'($urandom),
            5'($urandom_range(22, 24)), 7'($urandom_range(0, 79))));
        end
      end else begin
        op = tccw_pkg::tccw_in_t'(30'($urandom));
        queued_ops.push_back(op);
      end
    end
  endtask

  // sender pause: everything queued is sent and every result is back
  task automatic wait_all_reported();
    while (queued_ops.size() != 0 || in_valid || awaited_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_blank_style(input logic [7:0] style);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= style;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    blank_style = style;
  endtask

  // stimulus sequence
  initial begin
    blank_style = tccw_pkg::RESET_STYLE;
    cursor_pos  = 0;
    blank_screen();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, saturation, both scroll causes, clear
    queued_ops.push_back(pack_op(tccw_pkg::OP_READ, 8'h00, 8'h00, 5'd0, 7'd0));
    queued_ops.push_back(pack_op(tccw_pkg::OP_WRITE, 8'h00, 8'hFF, 5'd0, 7'd0));
    queued_ops.push_back(pack_op(tccw_pkg::OP_WRITE, 8'hFF, 8'h00, 5'd31, 7'd127));
    queued_ops.push_back(pack_op(tccw_pkg::OP_WRITE, tccw_pkg::NEWLINE_CHAR, 8'h33, 5'd0, 7'd0));
    queued_ops.push_back(pack_op(tccw_pkg::OP_READ, 8'h00, 8'h00, 5'd0, 7'd0));
    queued_ops.push_back(pack_op(tccw_pkg::OP_READ, 8'h00, 8'h00, 5'd0, 7'd1));
    queued_ops.push_back(pack_op(tccw_pkg::OP_SET_CURSOR, 8'h00, 8'h00, 5'd31, 7'd127));
    queued_ops.push_back(pack_op(tccw_pkg::OP_WRITE, 8'h5A, 8'hA5, 5'd0, 7'd0));
    queued_ops.push_back(pack_op(tccw_pkg::OP_READ, 8'h00, 8'h00, 5'd23, 7'd79));
    queued_ops.push_back(pack_op(tccw_pkg::OP_READ, 8'h00, 8'h00, 5'd24, 7'd0));
    queued_ops.push_back(pack_op(tccw_pkg::OP_SET_CURSOR, 8'h00, 8'h00, 5'd24, 7'd5));
    queued_ops.push_back(pack_op(tccw_pkg::OP_WRITE, 8'h41, 8'h1E, 5'd0, 7'd0));
    queued_ops.push_back(pack_op(tccw_pkg::OP_WRITE, tccw_pkg::NEWLINE_CHAR, 8'h00, 5'd0, 7'd0));
    queued_ops.push_back(pack_op(tccw_pkg::OP_READ, 8'h00, 8'h00, 5'd31, 7'd127));
    queued_ops.push_back(pack_op(tccw_pkg::OP_READ, 8'h00, 8'h00, 5'd22, 7'd79));
    queued_ops.push_back(pack_op(tccw_pkg::OP_READ, 8'h00, 8'h00, 5'd23, 7'd5));
    queued_ops.push_back(pack_op(tccw_pkg::OP_SET_CURSOR, 8'h00, 8'h00, 5'd0, 7'd100));
    queued_ops.push_back(pack_op(tccw_pkg::OP_WRITE, 8'hAA, 8'h55, 5'd0, 7'd0));
    queued_ops.push_back(pack_op(tccw_pkg::OP_SET_CURSOR, 8'h00, 8'h00, 5'd30, 7'd0));
    queued_ops.push_back(pack_op(tccw_pkg::OP_CLEAR, 8'hFF, 8'hFF, 5'd31, 7'd127));
    queued_ops.push_back(pack_op(tccw_pkg::OP_READ, 8'h00, 8'h00, 5'd10, 7'd10));
    queued_ops.push_back(pack_op(tccw_pkg::OP_WRITE, 8'h55, 8'hAA, 5'd0, 7'd0));
    queued_ops.push_back(pack_op(tccw_pkg::OP_READ, 8'hFF, 8'hFF, 5'd0, 7'd0));
    wait_all_reported();

    write_blank_style(8'h00);
    queue_phase(300);
    wait_all_reported();

    // long receiver hold while the sender keeps offering
    write_blank_style(8'hFF);
    hold_request <= 1'b1;
    queue_phase(300);
    wait_all_reported();

    write_blank_style(8'($urandom_range(1, 254)));
    queue_phase(300);
    wait_all_reported();

    // closing stretch with no idling on either side
    write_blank_style(8'($urandom));
    quiet_run <= 1'b1;
    queue_phase(250);
    wait_all_reported();

    repeat (16) @(posedge clk);
    if (fault_count == 0 && awaited_reports.size() == 0) begin
      $display("[text_console_cell_writer_unit] OK");
    end else begin
      $display("[text_console_cell_writer_unit] ERROR");
    end
    $finish;
  end

  // input driver with random gap bursts between transfers
  int unsigned in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (queued_ops.size() != 0) begin
        in_data  <= queued_ops.pop_front();
        in_valid <= 1'b1;
        if (!quiet_run && $urandom_range(0, 4) == 0) in_gap <= $urandom_range(1, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: stall bursts, plus one long hold on request
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left != 1);
    end else if (quiet_run) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 3) == 0);
      stall_left <= $urandom_range(1, 16);
    end
  end

  // predict on every input transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) awaited_reports.push_back(apply_console_op(in_data));
  end

  // compare every result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    tccw_pkg::tccw_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_reports.size() == 0) begin
        $error("result transfer with no prediction waiting: %h", out_data);
        fault_count++;
      end else begin
        want = awaited_reports.pop_front();
        if (out_data.cursor_offset !== want.cursor_offset) begin
          $error("cursor_offset expected %0d actual %0d", want.cursor_offset,
                 out_data.cursor_offset);
          fault_count++;
        end
        if (out_data.cell_char !== want.cell_char) begin
          $error("cell_char expected %h actual %h", want.cell_char, out_data.cell_char);
          fault_count++;
        end
        if (out_data.cell_style !== want.cell_style) begin
          $error("cell_style expected %h actual %h", want.cell_style, out_data.cell_style);
          fault_count++;
        end
        if (out_data.scrolled !== want.scrolled) begin
          $error("scrolled expected %b actual %b", want.scrolled, out_data.scrolled);
          fault_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[text_console_cell_writer_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### files.f
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_front.sv
hw/rtl/tccw_queue.sv
hw/rtl/tccw_back.sv
hw/rtl/text_console_cell_writer_unit.sv
sim/text_console_cell_writer_unit_tb.sv
